/* sv/pffs_pkg.sv */
`timescale 1ns / 1ps
// pffs_pkg: request and response structs, opcodes, register indexes and the
// console default palette for the palette fade/flash sequencer
// no dependencies

package pffs_pkg;

   localparam int PALETTE_ENTRIES_DEF = 16;
   localparam int MAX_STEPS_DEF       = 15;
   localparam int DEFAULT_COUNT       = 16;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_HOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_HOLD = 2'd1;

   localparam logic [15:0] BLEND_HOLD_RESET = 16'd20;
   localparam logic [15:0] FLASH_HOLD_RESET = 16'd50;

   localparam logic [2:0] OP_SET    = 3'd0;
   localparam logic [2:0] OP_BLEND  = 3'd1;
   localparam logic [2:0] OP_BLEND2 = 3'd2;
   localparam logic [2:0] OP_FLASH  = 3'd3;
   localparam logic [2:0] OP_FLASH2 = 3'd4;
   localparam logic [2:0] OP_RESET  = 3'd5;

   // [0] red, [1] green, [2] blue
   typedef logic [2:0][7:0] color_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] entry_index;
      logic [3:0] step_count;
      logic [7:0] red_a;
      logic [7:0] green_a;
      logic [7:0] blue_a;
      logic [7:0] red_b;
      logic [7:0] green_b;
      logic [7:0] blue_b;
   } req_type;

   typedef struct packed {
      logic [3:0]  write_index;
      logic [7:0]  write_red;
      logic [7:0]  write_green;
      logic [7:0]  write_blue;
      logic [15:0] hold_ms;
      logic        last_write;
   } rsp_type;

   function automatic color_type default_color(input logic [3:0] idx);
      color_type c;
      case (idx)
         4'd0: c = {8'h00, 8'h00, 8'h00};
         4'd1: c = {8'h00, 8'h00, 8'hAA};
         4'd2: c = {8'h00, 8'hAA, 8'h00};
         4'd3: c = {8'h00, 8'h55, 8'hAA};
         4'd4: c = {8'hAA, 8'h00, 8'h00};
         4'd5: c = {8'hAA, 8'h00, 8'hAA};
         4'd6: c = {8'hAA, 8'hAA, 8'h00};
         4'd7: c = {8'hAA, 8'hAA, 8'hAA};
         4'd8: c = {8'h55, 8'h55, 8'h55};
         4'd9: c = {8'h55, 8'h55, 8'hFF};
         4'd10: c = {8'h55, 8'hFF, 8'h55};
         4'd11: c = {8'h55, 8'hFF, 8'hFF};
         4'd12: c = {8'hFF, 8'h55, 8'h55};
         4'd13: c = {8'hFF, 8'h55, 8'hFF};
         4'd14: c = {8'hFF, 8'hFF, 8'h55};
         default: c = {8'hFF, 8'hFF, 8'hFF};
      endcase
      return c;
   endfunction

endpackage

/* sv/palette_fade_flash_sequencer_top.sv */
`timescale 1ns / 1ps
// set, reset, nonzero-step flash and zero-step blends go from idle to the direct state,
// which registers the write; other blends pass through load and divide states first;
// flash and reset then write every cycle. Each blend write runs 3 components, each a load
// then a 12-bit restoring divide. Busy until the last write; start is taken only when idle.
// sync active-high reset clears control state, hold registers go to 20 ms and 50 ms
// depends on pffs_pkg

module palette_fade_flash_sequencer_top
   import pffs_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
   parameter int MAX_STEPS       = MAX_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   localparam int RST_COUNT = (PALETTE_ENTRIES < DEFAULT_COUNT) ? PALETTE_ENTRIES
                                                               : DEFAULT_COUNT;
   localparam logic [3:0] RST_LAST  = 4'(RST_COUNT - 1);
   localparam logic [3:0] STEPS_MAX = 4'(MAX_STEPS);
   localparam int DIV_W = 12;
   localparam logic [3:0] DIV_LAST = 4'(DIV_W - 1);

   typedef enum logic [1:0] {S_IDLE, S_DIRECT, S_LOAD, S_DIV} state_type;

   state_type   state_ff;
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff;
   logic [15:0] blend_hold_ff;
   logic [15:0] flash_hold_ff;

   logic [2:0]  op_ff;
   logic [3:0]  idx_ff;
   logic [3:0]  steps_ff;
   color_type   a_ff;
   color_type   b_ff;
   logic        phase_ff;
   logic [3:0]  i_ff;
   logic        pick_ff;
   logic [1:0]  comp_ff;
   color_type   mix_ff;

   logic        neg_ff;
   logic [7:0]  first_ff;
   logic [DIV_W-1:0] div_num_ff;
   logic [3:0]  div_rem_ff;
   logic [3:0]  div_cnt_ff;

   // request decode
   logic [3:0]  steps_sat;
   logic        idx_ok;
   state_type   go_state;

   // per-write sequencing
   color_type   first_c;
   color_type   second_c;
   color_type   direct_c;
   logic        lop;
   logic        single;
   logic        last_w;
   logic        nxt_phase;
   logic [3:0]  nxt_i;
   logic        nxt_pick;
   logic [15:0] hold_c;

   // shared divider and lerp
   logic [7:0]  ld_first;
   logic [7:0]  ld_second;
   logic [7:0]  ld_absd;
   logic [DIV_W-1:0] ld_prod;
   logic [4:0]  rem_sh;
   logic        q_bit;
   logic [3:0]  div_rem_in;
   logic [DIV_W-1:0] div_num_in;
   logic [7:0]  mix_val;
   color_type   mix_in;

   rsp_type     emit_direct;
   rsp_type     emit_mix;

   always_comb begin
      steps_sat = (req_data.step_count > STEPS_MAX) ? STEPS_MAX : req_data.step_count;
      idx_ok = int'(req_data.entry_index) < PALETTE_ENTRIES;
      go_state = S_IDLE;
      case (req_data.opcode)
         OP_RESET: go_state = S_DIRECT;
         OP_SET: go_state = idx_ok ? S_DIRECT : S_IDLE;
         OP_BLEND, OP_BLEND2: begin
            if (idx_ok) go_state = (steps_sat == 4'd0) ? S_DIRECT : S_LOAD;
         end
         OP_FLASH, OP_FLASH2: begin
            if (idx_ok && steps_sat != 4'd0) go_state = S_DIRECT;
         end
         default: go_state = S_IDLE;
      endcase
   end

   always_comb begin
      // second half of a there-and-back command swaps the colors
      first_c  = phase_ff ? b_ff : a_ff;
      second_c = phase_ff ? a_ff : b_ff;
      single   = !(op_ff == OP_BLEND2 || op_ff == OP_FLASH2);
      nxt_phase = phase_ff;
      nxt_i     = i_ff;
      nxt_pick  = pick_ff;
      case (op_ff)
         OP_RESET: begin
            lop = (i_ff == RST_LAST);
            direct_c = default_color(i_ff);
            hold_c = 16'd0;
            nxt_i = i_ff + 4'd1;
         end
         OP_BLEND, OP_BLEND2: begin
            // zero steps also ends the phase on its only write
            lop = (i_ff == steps_ff);
            direct_c = first_c;
            hold_c = blend_hold_ff;
            if (lop) begin
               nxt_phase = 1'b1;
               nxt_i = 4'd0;
            end else begin
               nxt_i = i_ff + 4'd1;
            end
         end
         OP_FLASH, OP_FLASH2: begin
            lop = pick_ff && (i_ff == steps_ff - 4'd1);
            direct_c = pick_ff ? second_c : first_c;
            hold_c = flash_hold_ff;
            nxt_pick = !pick_ff;
            if (pick_ff) begin
               if (lop) begin
                  nxt_phase = 1'b1;
                  nxt_i = 4'd0;
               end else begin
                  nxt_i = i_ff + 4'd1;
               end
            end
         end
         default: begin
            lop = 1'b1;
            direct_c = a_ff;
            hold_c = 16'd0;
         end
      endcase
      last_w = lop && (single || phase_ff);
   end

   always_comb begin
      ld_first  = first_c[comp_ff];
      ld_second = second_c[comp_ff];
      ld_absd   = (ld_second >= ld_first) ? ld_second - ld_first : ld_first - ld_second;
      ld_prod   = DIV_W'(ld_absd) * DIV_W'(i_ff);

      rem_sh     = {div_rem_ff, div_num_ff[DIV_W-1]};
      q_bit      = rem_sh >= {1'b0, steps_ff};
      div_rem_in = q_bit ? 4'(rem_sh - {1'b0, steps_ff}) : rem_sh[3:0];
      div_num_in = {div_num_ff[DIV_W-2:0], q_bit};

      // quotient never exceeds the color difference, so 8 bits suffice
      mix_val = neg_ff ? first_ff - div_num_in[7:0] : first_ff + div_num_in[7:0];
      mix_in = mix_ff;
      mix_in[comp_ff] = mix_val;
   end

   always_comb begin
      emit_direct.write_index = (op_ff == OP_RESET) ? i_ff : idx_ff;
      emit_direct.write_red   = direct_c[0];
      emit_direct.write_green = direct_c[1];
      emit_direct.write_blue  = direct_c[2];
      emit_direct.hold_ms     = hold_c;
      emit_direct.last_write  = last_w;
      emit_mix = emit_direct;
      emit_mix.write_red   = mix_in[0];
      emit_mix.write_green = mix_in[1];
      emit_mix.write_blue  = mix_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         blend_hold_ff <= BLEND_HOLD_RESET;
         flash_hold_ff <= FLASH_HOLD_RESET;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_BLEND_HOLD: blend_hold_ff <= csr_wdata;
               CSR_FLASH_HOLD: flash_hold_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_data.opcode;
                  idx_ff   <= req_data.entry_index;
                  steps_ff <= steps_sat;
                  a_ff     <= {req_data.blue_a, req_data.green_a, req_data.red_a};
                  b_ff     <= {req_data.blue_b, req_data.green_b, req_data.red_b};
                  phase_ff <= 1'b0;
                  i_ff     <= 4'd0;
                  pick_ff  <= 1'b0;
                  comp_ff  <= 2'd0;
                  state_ff <= go_state;
               end
            end
            S_DIRECT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_ff   <= emit_direct;
               phase_ff <= nxt_phase;
               i_ff     <= nxt_i;
               pick_ff  <= nxt_pick;
               if (last_w) state_ff <= S_IDLE;
            end
            S_LOAD: begin
               neg_ff     <= ld_second < ld_first;
               first_ff   <= ld_first;
               div_num_ff <= ld_prod;
               div_rem_ff <= 4'd0;
               div_cnt_ff <= 4'd0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_rem_in;
               div_cnt_ff <= div_cnt_ff + 4'd1;
               if (div_cnt_ff == DIV_LAST) begin
                  mix_ff <= mix_in;
                  if (comp_ff == 2'd2) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_ff   <= emit_mix;
                     phase_ff <= nxt_phase;
                     i_ff     <= nxt_i;
                     comp_ff  <= 2'd0;
                     state_ff <= last_w ? S_IDLE : S_LOAD;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= S_LOAD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("write strobed without a request in progress");

   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_write |-> !busy)
      else $error("still busy after the final write");

   a_idle_only_after_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe && rsp_data.last_write)
      else $error("request ended without a final write");

   a_div_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> {1'b0, div_rem_ff} < {1'b0, steps_ff})
      else $error("divider remainder out of range");

endmodule
